// ===== rtl/core/tmps_pkg.sv =====
package tmps_pkg;

  localparam int unsigned ENTRY_W     = 8;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned ROW_OUT_W   = 4;
  localparam int unsigned COL_OUT_W   = 4;
  localparam int unsigned RIU_W       = 5;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [RIU_W-1:0] ROWS_RESET = RIU_W'(15);

  // register index, taken from paddr[2]
  localparam logic REG_ROWS_IN_USE = 1'b0;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             go_right;
  } pick_t;

endpackage

// ===== rtl/core/tmps_ram.sv =====
module tmps_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tmps_pick.sv =====
module tmps_pick (
  input  logic [tmps_pkg::SUM_W-1:0]   left_i,
  input  logic [tmps_pkg::SUM_W-1:0]   right_i,
  input  logic [tmps_pkg::ENTRY_W-1:0] entry_i,
  output tmps_pkg::pick_t              pick_o
);

  logic [tmps_pkg::SUM_W-1:0] larger;
  logic [tmps_pkg::SUM_W:0]   raw_sum;

  // tie goes to the right-hand child
  always_comb begin
    pick_o.go_right = !(left_i > right_i);
    larger          = pick_o.go_right ? right_i : left_i;
    raw_sum         = {1'b0, larger} + (tmps_pkg::SUM_W + 1)'(entry_i);
    pick_o.sum      = raw_sum[tmps_pkg::SUM_W] ? tmps_pkg::SUM_MAX
                                               : raw_sum[tmps_pkg::SUM_W-1:0];
  end

endmodule

// ===== rtl/core/triangle_max_path_sum.sv =====
// Maximum top-to-bottom path sum of a number triangle. Entries arrive on the
// slave stream one per beat, row by row and left to right, until the
// triangle of rows_in_use rows (0 acts as 1, values above MAX_ROWS act as
// MAX_ROWS) is complete; while loading, one beat is taken per cycle. The
// beat that completes the triangle starts the computation and the slave side
// stays not ready until the last result has been handed to the output
// register. The bottom row is copied with a read and a write per entry,
// each upper row begins by reading row sum 0 and latching the left child
// and then reads and writes each cell; the path walk hands out each row's
// result and follows its choice bit. This order is set by the one registered
// row-sum read port and the single compare-add unit that serves every cell.
// One result beat per row follows, apex first, carrying the best total, the
// row and the column taken; tlast marks the bottom row. A tie between the
// two children takes the right one. rows_in_use may be rewritten between
// entries of a load: the count of loaded entries is kept and the computation
// starts on the first entry that takes it to or past the new entry count.
module triangle_max_path_sum #(
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [tmps_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [7:0] entry_value
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [11:0] best_total, [15:12] path_row, [19:16] path_column, [23:20] zero
  output logic [tmps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,  // path_last
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tmps_pkg::APB_AW-1:0]           paddr,
  input  logic [tmps_pkg::APB_DW-1:0]           pwdata,
  output logic [tmps_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);

  localparam int unsigned CELLS  = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_ROWS);
  localparam int unsigned NR_W   = $clog2(MAX_ROWS + 1);

  localparam int unsigned ENTRY_W = tmps_pkg::ENTRY_W;
  localparam int unsigned SUM_W   = tmps_pkg::SUM_W;
  localparam int unsigned RIU_W   = tmps_pkg::RIU_W;

  typedef enum logic [3:0] {
    S_LOAD,       // taking entries
    S_COPY_RD,    // bottom row: read entry
    S_COPY_WR,    // bottom row: write row sum
    S_ROW_START,  // read row sum 0
    S_ROW_LEFT,   // latch left child of cell 0
    S_CELL_RD,    // read right child and own entry
    S_CELL_WR,    // compare, add, write back
    S_WALK_OUT,   // hand one result to the output register
    S_WALK_STEP   // follow the choice bit
  } state_e;

  // ---------------------------------------------------------------- registers
  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        load_cnt_q, load_cnt_d;
  logic [RIU_W-1:0]        rows_q, rows_d;
  logic                    out_valid_q, out_valid_d;

  logic [NR_W-1:0]         n_q, n_d;          // active rows of this run
  logic [IDX_W-1:0]        r_q, r_d;          // row counter
  logic [IDX_W-1:0]        c_q, c_d;          // cell counter, column on the walk
  logic [CELL_W-1:0]       base_q, base_d;    // first cell of the row at work
  logic [SUM_W-1:0]        total_q, total_d;  // best sum at the apex
  logic [SUM_W-1:0]        prev_q, prev_d;    // old sum of the left child

  logic [SUM_W-1:0]                 out_total_q, out_total_d;
  logic [tmps_pkg::ROW_OUT_W-1:0]   out_row_q, out_row_d;
  logic [tmps_pkg::COL_OUT_W-1:0]   out_col_q, out_col_d;
  logic                             out_last_q, out_last_d;

  // ---------------------------------------------------------------- memories
  logic                ent_we;
  logic [CELL_W-1:0]   ent_waddr, ent_raddr;
  logic [ENTRY_W-1:0]  ent_rdata;

  logic                best_we;
  logic [IDX_W-1:0]    best_waddr, best_raddr;
  logic [SUM_W-1:0]    best_wdata, best_rdata;

  logic                ch_we;
  logic [CELL_W-1:0]   ch_waddr, ch_raddr;
  logic                ch_rdata;

  tmps_pkg::pick_t     pick;

  tmps_ram #(.DEPTH(CELLS), .WIDTH(ENTRY_W)) u_entry_store (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (s_axis_tdata[ENTRY_W-1:0]),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  tmps_ram #(.DEPTH(MAX_ROWS), .WIDTH(SUM_W)) u_row_sums (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata)
  );

  tmps_ram #(.DEPTH(CELLS), .WIDTH(1)) u_choices (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (pick.go_right),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  // ---------------------------------------------------------------- shared unit
  tmps_pick u_pick (
    .left_i  (prev_q),
    .right_i (best_rdata),
    .entry_i (ent_rdata),
    .pick_o  (pick)
  );

  // ---------------------------------------------------------------- row count
  logic [NR_W-1:0]     n_act;
  logic [2*NR_W-1:0]   tri_prod;
  logic [CNT_W-1:0]    cell_total;
  logic [CNT_W-1:0]    cnt_inc;

  always_comb begin
    if (rows_q == '0) begin
      n_act = NR_W'(1);
    end else if ({1'b0, rows_q} > (RIU_W + 1)'(MAX_ROWS)) begin
      n_act = NR_W'(MAX_ROWS);
    end else begin
      n_act = NR_W'(rows_q);
    end
    tri_prod   = (2 * NR_W)'(n_act) * ((2 * NR_W)'(n_act) + (2 * NR_W)'(1));
    cell_total = CNT_W'(tri_prod >> 1);
    cnt_inc    = load_cnt_q + CNT_W'(1);
  end

  // ---------------------------------------------------------------- register port
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[tmps_pkg::APB_AW-1] == tmps_pkg::REG_ROWS_IN_USE);
  assign prdata    = (paddr[tmps_pkg::APB_AW-1] == tmps_pkg::REG_ROWS_IN_USE)
                     ? tmps_pkg::APB_DW'(rows_q) : '0;

  // ---------------------------------------------------------------- sequencer
  logic out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    rows_d      = cfg_write ? pwdata[RIU_W-1:0] : rows_q;
    out_valid_d = (out_valid_q && m_axis_tready) ? 1'b0 : out_valid_q;
    n_d         = n_q;
    r_d         = r_q;
    c_d         = c_q;
    base_d      = base_q;
    total_d     = total_q;
    prev_d      = prev_q;
    out_total_d = out_total_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;

    ent_we     = 1'b0;
    ent_waddr  = load_cnt_q[CELL_W-1:0];
    ent_raddr  = base_q + CELL_W'(c_q);
    best_we    = 1'b0;
    best_waddr = c_q;
    best_wdata = pick.sum;
    best_raddr = c_q + IDX_W'(1);
    ch_we      = 1'b0;
    ch_waddr   = base_q + CELL_W'(c_q);
    ch_raddr   = base_q + CELL_W'(c_q);

    case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid) begin
          ent_we = 1'b1;
          if (cnt_inc >= cell_total) begin
            load_cnt_d = '0;
            n_d        = n_act;
            base_d     = CELL_W'(cell_total - CNT_W'(n_act));
            c_d        = '0;
            state_d    = S_COPY_RD;
          end else begin
            load_cnt_d = cnt_inc;
          end
        end
      end

      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end

      S_COPY_WR: begin
        best_we    = 1'b1;
        best_wdata = SUM_W'(ent_rdata);
        if (c_q == '0) begin
          total_d = SUM_W'(ent_rdata);
        end
        if ((NR_W'(c_q) + NR_W'(1)) == n_q) begin
          if (n_q == NR_W'(1)) begin
            r_d     = '0;
            c_d     = '0;
            base_d  = '0;
            state_d = S_WALK_OUT;
          end else begin
            r_d     = IDX_W'(n_q - NR_W'(1));
            base_d  = base_q - CELL_W'(n_q - NR_W'(1));
            state_d = S_ROW_START;
          end
        end else begin
          c_d     = c_q + IDX_W'(1);
          state_d = S_COPY_RD;
        end
      end

      S_ROW_START: begin
        best_raddr = '0;
        c_d        = '0;
        state_d    = S_ROW_LEFT;
      end

      S_ROW_LEFT: begin
        prev_d  = best_rdata;
        state_d = S_CELL_RD;
      end

      S_CELL_RD: begin
        state_d = S_CELL_WR;
      end

      S_CELL_WR: begin
        best_we = 1'b1;
        ch_we   = 1'b1;
        prev_d  = best_rdata;
        if (c_q == '0) begin
          total_d = pick.sum;
        end
        if ((c_q + IDX_W'(1)) == r_q) begin
          if (r_q == IDX_W'(1)) begin
            r_d     = '0;
            c_d     = '0;
            base_d  = '0;
            state_d = S_WALK_OUT;
          end else begin
            r_d     = r_q - IDX_W'(1);
            base_d  = base_q - CELL_W'(r_q - IDX_W'(1));
            state_d = S_ROW_START;
          end
        end else begin
          c_d     = c_q + IDX_W'(1);
          state_d = S_CELL_RD;
        end
      end

      S_WALK_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_row_d   = tmps_pkg::ROW_OUT_W'(r_q);
          out_col_d   = tmps_pkg::COL_OUT_W'(c_q);
          out_last_d  = (NR_W'(r_q) + NR_W'(1)) == n_q;
          state_d     = ((NR_W'(r_q) + NR_W'(1)) == n_q) ? S_LOAD : S_WALK_STEP;
        end
      end

      S_WALK_STEP: begin
        c_d     = c_q + IDX_W'(ch_rdata);
        base_d  = base_q + CELL_W'(r_q) + CELL_W'(1);
        r_d     = r_q + IDX_W'(1);
        state_d = S_WALK_OUT;
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // sequencer state, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      rows_q      <= tmps_pkg::ROWS_RESET;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      base_q      <= '0;
      total_q     <= '0;
      prev_q      <= '0;
      out_total_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      rows_q      <= rows_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      r_q         <= r_d;
      c_q         <= c_d;
      base_q      <= base_d;
      total_q     <= total_d;
      prev_q      <= prev_d;
      out_total_q <= out_total_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'b0, out_col_q, out_row_q, out_total_q};

  // ---------------------------------------------------------------- checks
  // the load count never leaves the entry store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W + 1)'(load_cnt_q) < (CNT_W + 1)'(CELLS))
    else $error("load count beyond entry store");

  // a cell of the upper row always has a right child in the row below
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL_RD || state_q == S_CELL_WR) |-> (c_q < r_q))
    else $error("cell index past row end");

  // the walk never leaves the triangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_OUT || state_q == S_WALK_STEP) |-> (c_q <= r_q))
    else $error("path column beyond row");

  // the last result of a run belongs to the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_OUT && out_free &&
     (NR_W'(r_q) + NR_W'(1)) == n_q) |=> (out_valid_q && out_last_q && s_axis_tready))
    else $error("bottom row result not flagged");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROWS      = 16;
  localparam int unsigned CELLS         = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam time         CLK_PERIOD    = 10ns;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 8;     // loading takes one beat per cycle
  localparam int unsigned DRAIN_CYCLES  = 400;   // a full sixteen-row computation, plus slack
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned RAND_ITEMS    = 150;
  localparam int unsigned SCRIPT_LEN    = 36;

  // register byte addresses, the index sits in paddr[2]
  localparam logic [tmps_pkg::APB_AW-1:0] ADDR_ROWS  = {tmps_pkg::REG_ROWS_IN_USE, 2'b00};
  localparam logic [tmps_pkg::APB_AW-1:0] ADDR_SPARE = {~tmps_pkg::REG_ROWS_IN_USE, 2'b00};

  typedef enum logic [1:0] {DO_WRITE, DO_READ, DO_ENTRY} dir_op_e;
  typedef enum logic [1:0] {VAL_WIDE, VAL_TIED, VAL_EDGE} value_style_e;

  typedef struct packed {
    logic [tmps_pkg::SUM_W-1:0]     total;
    logic [tmps_pkg::ROW_OUT_W-1:0] row;
    logic [tmps_pkg::COL_OUT_W-1:0] col;
    logic                           last;
  } path_step_t;

  // typed rows carry a best total that is obvious from a one-row triangle,
  // reads carry the register value expected back
  typedef struct {
    dir_op_e                     op;
    logic [tmps_pkg::APB_AW-1:0] addr;
    int unsigned                 value;
    bit                          typed;
    logic [tmps_pkg::SUM_W-1:0]  total;
  } dir_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [tmps_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] entry_value
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // [11:0] best_total, [15:12] path_row, [19:16] path_column, [23:20] zero
  logic [tmps_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;   // path_last
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [tmps_pkg::APB_AW-1:0]      paddr;
  logic [tmps_pkg::APB_DW-1:0]      pwdata;
  logic [tmps_pkg::APB_DW-1:0]      prdata;
  logic                             pready;

  triangle_max_path_sum #(.MAX_ROWS(MAX_ROWS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow of the block: register, entry store, row sums and choice bits
  logic [tmps_pkg::RIU_W-1:0]   rows_cfg;
  logic [tmps_pkg::ENTRY_W-1:0] entry_mem [CELLS];
  int unsigned                  row_best  [MAX_ROWS];
  bit                           go_right  [CELLS];
  int unsigned                  loaded;

  path_step_t awaited_steps [$];   // path steps still to come out of the block
  path_step_t fresh_steps   [$];   // steps caused by the latest entry
  int unsigned errors;

  // knobs shared between stimulus and receiver
  bit feed_steady;
  bit drain_steady;
  bit hold_req;

  dir_row_t script [SCRIPT_LEN] = '{
    '{DO_READ,  ADDR_ROWS,  32'(tmps_pkg::ROWS_RESET), 1'b0, '0},  // value after reset
    '{DO_WRITE, ADDR_ROWS,  1,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  0,   1'b1, 12'd0},           // lowest entry
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b1, 12'd255},         // highest entry
    '{DO_WRITE, ADDR_ROWS,  0,   1'b0, '0},              // zero rows acts as one
    '{DO_READ,  ADDR_ROWS,  0,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  170, 1'b1, 12'd170},
    '{DO_ENTRY, ADDR_ROWS,  85,  1'b1, 12'd85},
    '{DO_WRITE, ADDR_SPARE, 2,   1'b0, '0},              // unmapped slot, ignored
    '{DO_READ,  ADDR_ROWS,  0,   1'b0, '0},
    '{DO_WRITE, ADDR_ROWS,  2,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  10,  1'b0, '0},              // tie below, right child wins
    '{DO_ENTRY, ADDR_ROWS,  7,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  7,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  1,   1'b0, '0},              // left child larger
    '{DO_ENTRY, ADDR_ROWS,  200, 1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  3,   1'b0, '0},
    '{DO_WRITE, ADDR_ROWS,  3,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},              // all ties, path hugs the right
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  255, 1'b0, '0},
    '{DO_WRITE, ADDR_ROWS,  5,   1'b0, '0},              // start a five-row load
    '{DO_ENTRY, ADDR_ROWS,  1,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  2,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  3,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  4,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  5,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  6,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  7,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  8,   1'b0, '0},
    '{DO_WRITE, ADDR_ROWS,  3,   1'b0, '0},              // shrink mid-load, count already past
    '{DO_READ,  ADDR_ROWS,  3,   1'b0, '0},
    '{DO_ENTRY, ADDR_ROWS,  9,   1'b0, '0}               // fires on the first six entries
  };

  function automatic int unsigned tri_base(input int unsigned r);
    return r * (r + 1) / 2;
  endfunction

  function automatic int unsigned rows_active(input logic [tmps_pkg::RIU_W-1:0] rows);
    if (rows < 1) return 1;
    if (rows > MAX_ROWS) return MAX_ROWS;
    return 32'(rows);
  endfunction

  // store one entry; once the triangle is complete, solve it bottom-up and
  // walk the choices from the apex into fresh_steps
  function automatic int unsigned triangle_step(input logic [tmps_pkg::ENTRY_W-1:0] v);
    int unsigned n, cells, base, r, c, col, pick;
    logic [tmps_pkg::SUM_W-1:0] best;
    n = rows_active(rows_cfg);
    cells = tri_base(n);
    fresh_steps.delete();
    if (loaded < CELLS) entry_mem[loaded] = v;
    loaded++;
    if (loaded < cells) return 0;
    loaded = 0;
    for (c = 0; c < n; c++) row_best[c] = 32'(entry_mem[tri_base(n - 1) + c]);
    for (r = n - 1; r > 0; r--) begin
      base = tri_base(r - 1);
      for (c = 0; c < r; c++) begin
        if (row_best[c] > row_best[c + 1]) begin
          pick = row_best[c];
          go_right[base + c] = 1'b0;
        end else begin
          pick = row_best[c + 1];
          go_right[base + c] = 1'b1;
        end
        pick += 32'(entry_mem[base + c]);
        if (pick > 32'(tmps_pkg::SUM_MAX)) pick = 32'(tmps_pkg::SUM_MAX);
        row_best[c] = pick;
      end
    end
    best = tmps_pkg::SUM_W'(row_best[0]);
    col = 0;
    for (r = 0; r < n; r++) begin
      fresh_steps.push_back('{best, tmps_pkg::ROW_OUT_W'(r), tmps_pkg::COL_OUT_W'(col),
                              r + 1 == n});
      if (r + 1 < n) col += 32'(go_right[tri_base(r) + col]);
    end
    return n;
  endfunction

  // offer one entry beat, hold it until taken, then maybe leave a gap
  task automatic send_entry(input logic [tmps_pkg::ENTRY_W-1:0] v, input bit typed,
                            input logic [tmps_pkg::SUM_W-1:0] typed_total);
    int unsigned n, gap, roll;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    n = triangle_step(v);
    if (typed && n > 0) awaited_steps.push_back('{typed_total, '0, '0, 1'b1});
    else foreach (fresh_steps[i]) awaited_steps.push_back(fresh_steps[i]);
    roll = $urandom_range(0, 99);
    if (feed_steady || roll < 45) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering, let every awaited path step out, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [tmps_pkg::APB_AW-1:0] a,
                           input logic [tmps_pkg::APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (a[2] == tmps_pkg::REG_ROWS_IN_USE) rows_cfg = d[tmps_pkg::RIU_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [tmps_pkg::APB_AW-1:0] a,
                          output logic [tmps_pkg::APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: checks each result beat and throttles tready
  initial begin : result_sink
    int unsigned stall_left, hold_left, roll;
    path_step_t seen, want;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.total = m_axis_tdata[tmps_pkg::SUM_W-1:0];
        seen.row   = m_axis_tdata[tmps_pkg::SUM_W +: tmps_pkg::ROW_OUT_W];
        seen.col   = m_axis_tdata[tmps_pkg::SUM_W + tmps_pkg::ROW_OUT_W +: tmps_pkg::COL_OUT_W];
        seen.last  = m_axis_tlast;
        if (awaited_steps.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, %s %0d row %0d col %0d last %0b",
                   $time, "got total", seen.total, seen.row, seen.col, seen.last);
        end else begin
          want = awaited_steps.pop_front();
          if (seen.total != want.total || seen.row != want.row ||
              seen.col != want.col || seen.last != want.last) begin
            errors++;
            $display("%0t: mismatch, expected total %0d row %0d col %0d last %0b,",
                     $time, want.total, want.row, want.col, want.last,
                     " got total %0d row %0d col %0d last %0b",
                     seen.total, seen.row, seen.col, seen.last);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      roll = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (drain_steady) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (roll < 3) begin
        stall_left = $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (roll >= 28);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic [tmps_pkg::APB_DW-1:0]  rd;
    logic [tmps_pkg::RIU_W-1:0]   rows;
    logic [tmps_pkg::ENTRY_W-1:0] v;
    value_style_e                 style;
    int unsigned                  p, n, cells, t, beats, rand_items;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rows_cfg        = tmps_pkg::ROWS_RESET;
    loaded          = 0;
    errors          = 0;
    feed_steady     = 1'b0;
    drain_steady    = 1'b0;
    hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk
    foreach (script[i]) begin
      case (script[i].op)
        DO_WRITE: begin
          wait_idle();
          apb_write(script[i].addr, script[i].value);
        end
        DO_READ: begin
          wait_idle();
          apb_read(script[i].addr, rd);
          if (rd != script[i].value) begin
            errors++;
            $display("%0t: register read, expected %0d, got %0d", $time, script[i].value, rd);
          end
        end
        default: begin
          send_entry(script[i].value[tmps_pkg::ENTRY_W-1:0], script[i].typed, script[i].total);
        end
      endcase
    end

    // random phases: first a small-triangle phase under receiver hold-off, then
    // an oversize row count that clamps to the largest triangle, then small
    // sizes with the odd torn load left behind for the next register write
    rand_items = 0;
    for (p = 0; p < 4 || rand_items < RAND_ITEMS; p++) begin
      case (p)
        0:       rows = tmps_pkg::RIU_W'(2);
        1:       rows = tmps_pkg::RIU_W'(31);
        default: rows = tmps_pkg::RIU_W'($urandom_range(0, 4));
      endcase
      wait_idle();
      apb_write(ADDR_ROWS, {(tmps_pkg::APB_DW-tmps_pkg::RIU_W)'($urandom()), rows});
      n     = rows_active(rows);
      cells = tri_base(n);
      beats = (p == 1) ? cells
            : (p == 0) ? 3 * cells : $urandom_range(1, 2) * cells;
      if (p >= 2 && cells > 1 && $urandom_range(0, 3) == 0)
        beats += $urandom_range(1, cells - 1);
      feed_steady  = (p == 0) || ($urandom_range(0, 3) == 0);
      drain_steady = (p != 0) && ($urandom_range(0, 3) == 0);
      style = value_style_e'($urandom_range(0, 2));
      if (p == 0) hold_req = 1'b1;
      for (t = 0; t < beats; t++) begin
        case (style)
          VAL_TIED: v = tmps_pkg::ENTRY_W'($urandom_range(0, 3));
          VAL_EDGE: v = ($urandom_range(0, 2) == 0)
                      ? tmps_pkg::ENTRY_W'($urandom_range(0, 255))
                      : ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
          default:  v = tmps_pkg::ENTRY_W'($urandom_range(0, 255));
        endcase
        send_entry(v, 1'b0, '0);
        rand_items++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
